// File: hw/rtl/bsc_pkg.sv
// Shared types, register codes and compensation constants for the barometric compensation block.
package bsc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned TDIV_DW = 27;
  localparam int unsigned TDIV_VW = 19;
  localparam int unsigned PDIV_DW = 32;
  localparam int unsigned PDIV_VW = 17;

  localparam logic [2:0] REG_COEFF_A      = 3'd0;
  localparam logic [2:0] REG_COEFF_B      = 3'd1;
  localparam logic [2:0] REG_COEFF_C      = 3'd2;
  localparam logic [2:0] REG_COEFF_D      = 3'd3;
  localparam logic [2:0] REG_OVERSAMPLING = 3'd4;

  localparam logic [1:0] OSS_RESET = 2'd1;

  localparam logic [11:0]        B6_OFFSET = 12'd4000;
  localparam logic [15:0]        P_BIAS    = 16'd32768;
  localparam logic [15:0]        P_SCALE   = 16'd50000;
  localparam logic [11:0]        P_C1      = 12'd3038;
  localparam logic signed [14:0] P_C2      = -15'sd7357;
  localparam logic [11:0]        P_C3      = 12'd3791;
  localparam logic [3:0]         T_ROUND   = 4'd8;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [1:0]         oss;
  } cfg_t;

  typedef struct packed {
    logic signed [18:0] x1;
    logic signed [19:0] dv;
    logic               dz;
    logic [18:0]        up;
  } front_req_t;

endpackage

// File: hw/rtl/bsc_front.sv
// Front end: takes an input request, forms the first temperature term and flags a zero divisor.
module bsc_front import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_temperature_i,
  input  logic [18:0] raw_pressure_i,
  output logic        push_o,
  output front_req_t  push_data_o,
  input  logic        full_i
);

  logic               vld_q;
  logic [15:0]        ut_q;
  logic [18:0]        up_q;
  logic               load;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [18:0] x1;
  logic signed [19:0] dv;

  assign push_o     = vld_q && !full_i;
  assign in_stall_o = vld_q && full_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ut_q <= raw_temperature_i;
      up_q <= raw_pressure_i;
    end
  end

  assign diff = $signed({1'b0, ut_q}) - $signed({1'b0, cfg_i.ac6});
  assign prod = diff * $signed({1'b0, cfg_i.ac5});
  assign x1   = prod[33:15];
  assign dv   = {x1[18], x1} + {{4{cfg_i.md[15]}}, cfg_i.md};

  assign push_data_o.x1 = x1;
  assign push_data_o.dv = dv;
  assign push_data_o.dz = (dv == '0);
  assign push_data_o.up = up_q;

endmodule

// File: hw/rtl/bsc_queue.sv
// Short request queue between the front end and the compensation pipeline.
module bsc_queue import bsc_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  front_req_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output front_req_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  front_req_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
`endif

endmodule

// File: hw/rtl/bsc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
module bsc_divider #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 17,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [DW-1:0] quotient_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q  [DW];
  logic [VW-1:0] rem_q  [DW];
  logic [DW-1:0] num_q  [DW];
  logic [DW-1:0] quo_q  [DW];
  logic [VW-1:0] den_q  [DW];
  logic [TW-1:0] tag_q  [DW];

  logic          vld_in [DW];
  logic [VW-1:0] rem_in [DW];
  logic [DW-1:0] num_in [DW];
  logic [DW-1:0] quo_in [DW];
  logic [VW-1:0] den_in [DW];
  logic [TW-1:0] tag_in [DW];
  logic [VW:0]   trial  [DW];
  logic [VW:0]   diff   [DW];
  logic [VW-1:0] rem_d  [DW];
  logic [DW-1:0] quo_d  [DW];

  always_comb begin
    vld_in[0] = valid_i;
    rem_in[0] = '0;
    num_in[0] = dividend_i;
    quo_in[0] = '0;
    den_in[0] = divisor_i;
    tag_in[0] = tag_i;
    for (int k = 1; k < DW; k++) begin
      vld_in[k] = vld_q[k-1];
      rem_in[k] = rem_q[k-1];
      num_in[k] = num_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_q[k-1];
      tag_in[k] = tag_q[k-1];
    end
    for (int k = 0; k < DW; k++) begin
      trial[k] = {rem_in[k], num_in[k][DW-1]};
      diff[k]  = trial[k] - {1'b0, den_in[k]};
      if (trial[k] >= {1'b0, den_in[k]}) begin
        rem_d[k] = diff[k][VW-1:0];
        quo_d[k] = {quo_in[k][DW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][VW-1:0];
        quo_d[k] = {quo_in[k][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < DW; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DW; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= {num_in[k][DW-2:0], 1'b0};
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_in[k];
        tag_q[k] <= tag_in[k];
      end
    end
  end

  assign valid_o    = vld_q[DW-1];
  assign quotient_o = quo_q[DW-1];
  assign tag_o      = tag_q[DW-1];

endmodule

// File: hw/rtl/bsc_back.sv
// Back end: temperature division, pressure terms, pressure division, correction and output register.
module bsc_back import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  front_req_t         data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic [19:0]        pressure_pa_o,
  output logic               fault_o
);

  typedef struct packed {
    logic signed [18:0] x1;
    logic [18:0]        up;
    logic               neg;
    logic               dz;
  } tdiv_tag_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic               fault;
    logic               hi;
  } pdiv_tag_t;

  logic adv;

  // Temperature division
  logic [15:0]            mc_abs;
  logic [19:0]            dv_abs;
  tdiv_tag_t              td_in;
  tdiv_tag_t              td_out;
  logic                   td_vld;
  logic [TDIV_DW-1:0]     td_quo;

  // Stage 2
  logic                   s2_vld_q;
  logic signed [28:0]     s2_b5_q;
  logic [18:0]            s2_up_q;
  logic                   s2_dz_q;
  logic signed [27:0]     x2t;
  logic signed [28:0]     b5;

  // Stage 3
  logic                   s3_vld_q;
  logic signed [28:0]     s3_b6_q;
  logic signed [15:0]     s3_t_q;
  logic [18:0]            s3_up_q;
  logic                   s3_dz_q;
  logic [29:0]            tsum;
  logic [25:0]            tt;
  logic signed [15:0]     tclamp;

  // Stage 4
  logic                   s4_vld_q;
  logic [45:0]            s4_sq_q;
  logic [33:0]            s4_x2a_q;
  logic [31:0]            s4_x1c_q;
  logic signed [15:0]     s4_t_q;
  logic [18:0]            s4_up_q;
  logic                   s4_dz_q;
  logic signed [57:0]     sqf;
  logic signed [44:0]     pa2;
  logic signed [44:0]     pa3;

  // Stage 5
  logic                   s5_vld_q;
  logic [33:0]            s5_x1b_q;
  logic [33:0]            s5_x2c_q;
  logic [33:0]            s5_x2a_q;
  logic [31:0]            s5_x1c_q;
  logic signed [15:0]     s5_t_q;
  logic [18:0]            s5_up_q;
  logic                   s5_dz_q;
  logic signed [62:0]     pb2;
  logic signed [62:0]     pb1;

  // Stage 6
  logic                   s6_vld_q;
  logic [31:0]            s6_diffu_q;
  logic [31:0]            s6_xb_q;
  logic signed [15:0]     s6_t_q;
  logic                   s6_dz_q;
  logic [33:0]            x3;
  logic [33:0]            b3v;
  logic [31:0]            diffu;
  logic [33:0]            sc;
  logic [31:0]            xb;

  // Stage 7
  logic                   s7_vld_q;
  logic [16:0]            s7_b4_q;
  logic [31:0]            s7_b7_q;
  logic signed [15:0]     s7_t_q;
  logic                   s7_dz_q;
  logic [47:0]            pb4;
  logic [47:0]            pb7;
  logic [15:0]            scale;

  // Pressure division
  pdiv_tag_t              pd_in;
  pdiv_tag_t              pd_out;
  logic                   pd_vld;
  logic [PDIV_DW-1:0]     pd_quo;

  // Stages 8 to 10
  logic                   s8_vld_q;
  logic [32:0]            s8_p_q;
  logic signed [15:0]     s8_t_q;
  logic                   s8_fault_q;
  logic                   s9_vld_q;
  logic [49:0]            s9_sqp_q;
  logic signed [32:0]     s9_x2_q;
  logic [32:0]            s9_p_q;
  logic signed [15:0]     s9_t_q;
  logic                   s9_fault_q;
  logic                   s10_vld_q;
  logic [45:0]            s10_x1_q;
  logic signed [32:0]     s10_x2_q;
  logic [32:0]            s10_p_q;
  logic signed [15:0]     s10_t_q;
  logic                   s10_fault_q;
  logic [24:0]            ps;
  logic signed [48:0]     pm2;
  logic [61:0]            pm1;
  logic [47:0]            psum;
  logic [49:0]            pn;
  logic [19:0]            pclamp;

  // Output register
  logic                   out_vld_q;
  logic signed [15:0]     out_t_q;
  logic [19:0]            out_p_q;
  logic                   out_fault_q;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  assign mc_abs    = cfg_i.mc[15] ? 16'(-cfg_i.mc) : cfg_i.mc;
  assign dv_abs    = data_i.dv[19] ? 20'(-data_i.dv) : data_i.dv;
  assign td_in.x1  = data_i.x1;
  assign td_in.up  = data_i.up;
  assign td_in.neg = cfg_i.mc[15] ^ data_i.dv[19];
  assign td_in.dz  = data_i.dz;

  bsc_divider #(
    .DW (TDIV_DW),
    .VW (TDIV_VW),
    .TW ($bits(tdiv_tag_t))
  ) u_tdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (pop_o),
    .dividend_i ({mc_abs, 11'b0}),
    .divisor_i  (dv_abs[TDIV_VW-1:0]),
    .tag_i      (td_in),
    .valid_o    (td_vld),
    .quotient_o (td_quo),
    .tag_o      (td_out)
  );

  assign x2t = td_out.neg ? (28'd0 - {1'b0, td_quo}) : {1'b0, td_quo};
  assign b5  = {{10{td_out.x1[18]}}, td_out.x1} + {x2t[27], x2t};

  assign tsum = {s2_b5_q[28], s2_b5_q} + 30'(T_ROUND);
  assign tt   = tsum[29:4];
  always_comb begin
    if (tt[25] && (tt[24:15] != '1)) begin
      tclamp = 16'sh8000;
    end else if (!tt[25] && (tt[24:15] != '0)) begin
      tclamp = 16'sh7fff;
    end else begin
      tclamp = tt[15:0];
    end
  end

  assign sqf = s3_b6_q * s3_b6_q;
  assign pa2 = cfg_i.ac2 * s3_b6_q;
  assign pa3 = cfg_i.ac3 * s3_b6_q;

  assign pb2 = cfg_i.b2 * $signed({1'b0, s4_sq_q});
  assign pb1 = cfg_i.b1 * $signed({1'b0, s4_sq_q});

  // Only the low 32 bits of B3 and of the B4 term matter, so these sums run modulo 2^34.
  assign x3    = s5_x1b_q + s5_x2a_q;
  assign b3v   = (({{16{cfg_i.ac1[15]}}, cfg_i.ac1, 2'b00} + x3) << cfg_i.oss) + 34'd2;
  assign diffu = {13'b0, s5_up_q} - b3v[33:2];
  assign sc    = {{2{s5_x1c_q[31]}}, s5_x1c_q} + s5_x2c_q + 34'd2;
  assign xb    = sc[33:2] + 32'(P_BIAS);

  assign scale = P_SCALE >> cfg_i.oss;
  assign pb4   = cfg_i.ac4 * s6_xb_q;
  assign pb7   = s6_diffu_q * scale;

  assign pd_in.t     = s7_t_q;
  assign pd_in.fault = s7_dz_q || (s7_b4_q == '0);
  assign pd_in.hi    = s7_b7_q[31];

  bsc_divider #(
    .DW (PDIV_DW),
    .VW (PDIV_VW),
    .TW ($bits(pdiv_tag_t))
  ) u_pdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s7_vld_q),
    .dividend_i (s7_b7_q[31] ? s7_b7_q : {s7_b7_q[30:0], 1'b0}),
    .divisor_i  (s7_b4_q),
    .tag_i      (pd_in),
    .valid_o    (pd_vld),
    .quotient_o (pd_quo),
    .tag_o      (pd_out)
  );

  assign ps  = s8_p_q[32:8];
  assign pm2 = P_C2 * $signed({1'b0, s8_p_q});
  assign pm1 = s9_sqp_q * P_C1;

  assign psum = {2'b00, s10_x1_q} + {{15{s10_x2_q[32]}}, s10_x2_q} + 48'(P_C3);
  assign pn   = {17'b0, s10_p_q} + {{6{psum[47]}}, psum[47:4]};
  always_comb begin
    if (pn[49]) begin
      pclamp = '0;
    end else if (pn[48:20] != '0) begin
      pclamp = '1;
    end else begin
      pclamp = pn[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q  <= td_vld;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= pd_vld;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      out_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_b5_q     <= b5;
      s2_up_q     <= td_out.up;
      s2_dz_q     <= td_out.dz;

      s3_b6_q     <= s2_b5_q - 29'(B6_OFFSET);
      s3_t_q      <= tclamp;
      s3_up_q     <= s2_up_q;
      s3_dz_q     <= s2_dz_q;

      s4_sq_q     <= sqf[57:12];
      s4_x2a_q    <= pa2[44:11];
      s4_x1c_q    <= pa3[44:13];
      s4_t_q      <= s3_t_q;
      s4_up_q     <= s3_up_q;
      s4_dz_q     <= s3_dz_q;

      s5_x1b_q    <= pb2[44:11];
      s5_x2c_q    <= pb1[49:16];
      s5_x2a_q    <= s4_x2a_q;
      s5_x1c_q    <= s4_x1c_q;
      s5_t_q      <= s4_t_q;
      s5_up_q     <= s4_up_q;
      s5_dz_q     <= s4_dz_q;

      s6_diffu_q  <= diffu;
      s6_xb_q     <= xb;
      s6_t_q      <= s5_t_q;
      s6_dz_q     <= s5_dz_q;

      s7_b4_q     <= pb4[31:15];
      s7_b7_q     <= pb7[31:0];
      s7_t_q      <= s6_t_q;
      s7_dz_q     <= s6_dz_q;

      s8_p_q      <= pd_out.hi ? {pd_quo, 1'b0} : {1'b0, pd_quo};
      s8_t_q      <= pd_out.t;
      s8_fault_q  <= pd_out.fault;

      s9_sqp_q    <= ps * ps;
      s9_x2_q     <= pm2[48:16];
      s9_p_q      <= s8_p_q;
      s9_t_q      <= s8_t_q;
      s9_fault_q  <= s8_fault_q;

      s10_x1_q    <= pm1[61:16];
      s10_x2_q    <= s9_x2_q;
      s10_p_q     <= s9_p_q;
      s10_t_q     <= s9_t_q;
      s10_fault_q <= s9_fault_q;

      out_t_q     <= s10_fault_q ? '0 : s10_t_q;
      out_p_q     <= s10_fault_q ? '0 : pclamp;
      out_fault_q <= s10_fault_q;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign temperature_tenths_o = out_t_q;
  assign pressure_pa_o        = out_p_q;
  assign fault_o              = out_fault_q;

endmodule

// File: hw/rtl/barometric_sensor_compensation.sv
// Top level of the barometric compensation block: configuration registers, front end, queue, back end.
// A request passes the front end, the queue and the back-end pipeline to the output register.
// Throughput: one request per cycle unless out_stall_i is high; pipelined dividers of 27 and 32 stages.
// A short queue decouples the front end, so input is taken while a result waits, until it fills.
// Reset clears all valid state and queue pointers; coefficients reset to 0, oversampling to 1.
module barometric_sensor_compensation import bsc_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        raw_temperature_i,
  input  logic [18:0]        raw_pressure_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic [19:0]        pressure_pa_o,
  output logic               fault_o
);

  logic [47:0] coeff_a_q;
  logic [47:0] coeff_b_q;
  logic [31:0] coeff_c_q;
  logic [31:0] coeff_d_q;
  logic [1:0]  oss_q;
  logic [2:0]  reg_idx;
  logic        wr_en;
  cfg_t        cfg;

  logic        push;
  logic        full;
  logic        pop;
  logic        empty;
  front_req_t  push_data;
  front_req_t  pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_a_q <= '0;
      coeff_b_q <= '0;
      coeff_c_q <= '0;
      coeff_d_q <= '0;
      oss_q     <= OSS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COEFF_A:      coeff_a_q <= pwdata[47:0];
        REG_COEFF_B:      coeff_b_q <= pwdata[47:0];
        REG_COEFF_C:      coeff_c_q <= pwdata[31:0];
        REG_COEFF_D:      coeff_d_q <= pwdata[31:0];
        REG_OVERSAMPLING: oss_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEFF_A:      prdata = {16'b0, coeff_a_q};
      REG_COEFF_B:      prdata = {16'b0, coeff_b_q};
      REG_COEFF_C:      prdata = {32'b0, coeff_c_q};
      REG_COEFF_D:      prdata = {32'b0, coeff_d_q};
      REG_OVERSAMPLING: prdata = {62'b0, oss_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg.ac1 = coeff_a_q[47:32];
  assign cfg.ac2 = coeff_a_q[31:16];
  assign cfg.ac3 = coeff_a_q[15:0];
  assign cfg.ac4 = coeff_b_q[47:32];
  assign cfg.ac5 = coeff_b_q[31:16];
  assign cfg.ac6 = coeff_b_q[15:0];
  assign cfg.b1  = coeff_c_q[31:16];
  assign cfg.b2  = coeff_c_q[15:0];
  assign cfg.mc  = coeff_d_q[31:16];
  assign cfg.md  = coeff_d_q[15:0];
  assign cfg.oss = oss_q;

  bsc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .push_o            (push),
    .push_data_o       (push_data),
    .full_i            (full)
  );

  bsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  bsc_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .empty_i              (empty),
    .data_i               (pop_data),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .temperature_tenths_o (temperature_tenths_o),
    .pressure_pa_o        (pressure_pa_o),
    .fault_o              (fault_o)
  );

`ifndef NO_ASSERTIONS
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> temperature_tenths_o == '0 && pressure_pa_o == '0)
    else $error("faulted result carries nonzero values");
`endif

endmodule
